FILE: hdl/c65x_pkg.sv
// Package for the 6502 execute unit: decoded operation classes and the
// queue entry type shared by the decode front end and the execute back end.
// No dependencies.
package c65x_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [5:0] {
        OP_BAD, OP_NOP, OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_STA, OP_LDA, OP_CMP, OP_SBC,
        OP_LDX, OP_ASLA, OP_ROLA, OP_LSRA, OP_RORA, OP_TXA, OP_TAX, OP_DEX, OP_TXS,
        OP_TSX, OP_ASLM, OP_ROLM, OP_LSRM, OP_RORM, OP_STX, OP_DEC, OP_INC, OP_ANC,
        OP_ALR, OP_ARR, OP_AXS, OP_SLO, OP_RLA, OP_SRE, OP_RRA, OP_SAX, OP_LAS,
        OP_LAX, OP_DCP, OP_ISC, OP_BRANCH, OP_PHP, OP_PLP, OP_PHA, OP_PLA, OP_DEY,
        OP_TAY, OP_INY, OP_INX, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_TYA, OP_CLV,
        OP_CLD, OP_SED, OP_LDY, OP_CPY, OP_CPX, OP_BIT, OP_STY
    } op_class_t;

    typedef struct packed {
        op_class_t  op;
        logic [2:0] aaa;
        logic [7:0] operand;
    } exec_item_t;

endpackage

FILE: hdl/cpu_6502_execute_unit.sv
// 6502 execute unit (binary arithmetic only). One instruction is accepted per
// cycle while m_ready does not stall the output; a result passes through the
// decode register, a QUEUE_DEPTH-entry queue (two by default), execute result register.
// Depends on c65x_pkg, c65x_decode, c65x_queue, c65x_execute.
module cpu_6502_execute_unit import c65x_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_opcode,
    input  logic [7:0] s_operand,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_acc_out,
    output logic [7:0] m_x_out,
    output logic [7:0] m_y_out,
    output logic [7:0] m_sp_out,
    output logic [7:0] m_status_out,
    output logic [7:0] m_write_data,
    output logic       m_write_enable,
    output logic       m_branch_taken,
    output logic       m_unsupported
);
    logic       dec_valid, dec_ready, q_valid, q_ready;
    exec_item_t dec_item, q_item;

    c65x_decode u_decode (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_operand(s_operand),
        .dec_valid(dec_valid), .dec_ready(dec_ready), .dec_item(dec_item)
    );

    c65x_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_valid(dec_valid), .wr_ready(dec_ready),
        .wr_item(dec_item), .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    c65x_execute u_execute (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .m_valid(m_valid), .m_ready(m_ready),
        .m_acc_out(m_acc_out), .m_x_out(m_x_out), .m_y_out(m_y_out),
        .m_sp_out(m_sp_out), .m_status_out(m_status_out),
        .m_write_data(m_write_data), .m_write_enable(m_write_enable),
        .m_branch_taken(m_branch_taken), .m_unsupported(m_unsupported)
    );
endmodule

FILE: hdl/c65x_decode.sv
// Front end: classifies each opcode into an operation class and registers it.
// Depends on c65x_pkg.
module c65x_decode import c65x_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_opcode,
    input  logic [7:0] s_operand,
    output logic       dec_valid,
    input  logic       dec_ready,
    output exec_item_t dec_item
);
    logic       valid_reg, valid_next;
    exec_item_t item_reg, item_next;
    op_class_t  cls;
    logic [1:0] cc;
    logic [2:0] aaa, bbb;
    logic [7:0] op;

    assign op  = s_opcode;
    assign cc  = op[1:0];
    assign aaa = op[7:5];
    assign bbb = op[4:2];

    always_comb begin
        cls = OP_NOP;
        case (cc)
            2'd1: begin
                case (aaa)
                    3'd0: cls = OP_ORA;
                    3'd1: cls = OP_AND;
                    3'd2: cls = OP_EOR;
                    3'd3: cls = OP_ADC;
                    3'd4: cls = (bbb != 3'd2) ? OP_STA : OP_NOP;
                    3'd5: cls = OP_LDA;
                    3'd6: cls = OP_CMP;
                    default: cls = OP_SBC;
                endcase
            end
            2'd2: begin
                if (bbb == 3'd4) begin
                    cls = OP_BAD;
                end else if (bbb == 3'd0) begin
                    if (aaa == 3'd5) cls = OP_LDX;
                    else if (aaa < 3'd4) cls = OP_BAD;
                end else if (bbb == 3'd2) begin
                    case (aaa)
                        3'd0: cls = OP_ASLA;
                        3'd1: cls = OP_ROLA;
                        3'd2: cls = OP_LSRA;
                        3'd3: cls = OP_RORA;
                        3'd4: cls = OP_TXA;
                        3'd5: cls = OP_TAX;
                        3'd6: cls = OP_DEX;
                        default: cls = OP_NOP;
                    endcase
                end else if (bbb == 3'd6) begin
                    if (aaa == 3'd4) cls = OP_TXS;
                    else if (aaa == 3'd5) cls = OP_TSX;
                end else begin
                    case (aaa)
                        3'd0: cls = OP_ASLM;
                        3'd1: cls = OP_ROLM;
                        3'd2: cls = OP_LSRM;
                        3'd3: cls = OP_RORM;
                        3'd4: cls = (op == 8'h9E) ? OP_BAD : OP_STX;
                        3'd5: cls = OP_LDX;
                        3'd6: cls = OP_DEC;
                        default: cls = OP_INC;
                    endcase
                end
            end
            2'd3: begin
                if (bbb == 3'd2) begin
                    case (aaa)
                        3'd0, 3'd1: cls = OP_ANC;
                        3'd2: cls = OP_ALR;
                        3'd3: cls = OP_ARR;
                        3'd4, 3'd5: cls = OP_BAD;
                        3'd6: cls = OP_AXS;
                        default: cls = OP_SBC;
                    endcase
                end else begin
                    case (aaa)
                        3'd0: cls = OP_SLO;
                        3'd1: cls = OP_RLA;
                        3'd2: cls = OP_SRE;
                        3'd3: cls = OP_RRA;
                        3'd4: cls = (op == 8'h93 || op == 8'h9F || op == 8'h9B)
                                    ? OP_BAD : OP_SAX;
                        3'd5: cls = (op == 8'hBB) ? OP_LAS : OP_LAX;
                        3'd6: cls = OP_DCP;
                        default: cls = OP_ISC;
                    endcase
                end
            end
            default: begin
                if (bbb == 3'd4) begin
                    cls = OP_BRANCH;
                end else if (bbb == 3'd2) begin
                    case (aaa)
                        3'd0: cls = OP_PHP;
                        3'd1: cls = OP_PLP;
                        3'd2: cls = OP_PHA;
                        3'd3: cls = OP_PLA;
                        3'd4: cls = OP_DEY;
                        3'd5: cls = OP_TAY;
                        3'd6: cls = OP_INY;
                        default: cls = OP_INX;
                    endcase
                end else if (bbb == 3'd6) begin
                    case (aaa)
                        3'd0: cls = OP_CLC;
                        3'd1: cls = OP_SEC;
                        3'd2: cls = OP_CLI;
                        3'd3: cls = OP_SEI;
                        3'd4: cls = OP_TYA;
                        3'd5: cls = OP_CLV;
                        3'd6: cls = OP_CLD;
                        default: cls = OP_SED;
                    endcase
                end else if (bbb == 3'd0) begin
                    case (aaa)
                        3'd4: cls = OP_NOP;
                        3'd5: cls = OP_LDY;
                        3'd6: cls = OP_CPY;
                        3'd7: cls = OP_CPX;
                        default: cls = OP_BAD;
                    endcase
                end else begin
                    case (aaa)
                        3'd1: cls = (bbb == 3'd1 || bbb == 3'd3) ? OP_BIT : OP_NOP;
                        3'd2, 3'd3: cls = (bbb == 3'd3) ? OP_BAD : OP_NOP;
                        3'd4: cls = (op == 8'h9C) ? OP_BAD :
                                    (bbb != 3'd7) ? OP_STY : OP_NOP;
                        3'd5: cls = OP_LDY;
                        3'd6: cls = (bbb == 3'd1 || bbb == 3'd3) ? OP_CPY : OP_NOP;
                        3'd7: cls = (bbb == 3'd1 || bbb == 3'd3) ? OP_CPX : OP_NOP;
                        default: cls = OP_NOP;
                    endcase
                end
            end
        endcase
    end

    assign s_ready   = !valid_reg || dec_ready;
    assign dec_valid = valid_reg;
    assign dec_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
            item_next  = '{op: cls, aaa: aaa, operand: s_operand};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end
endmodule

FILE: hdl/c65x_queue.sv
// Small FIFO that decouples decode from execute.
// Depends on c65x_pkg.
module c65x_queue import c65x_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  exec_item_t wr_item,
    output logic       rd_valid,
    input  logic       rd_ready,
    output exec_item_t rd_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    exec_item_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_item  = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) mem_reg[wp_reg] <= wr_item;
    end
endmodule

FILE: hdl/c65x_execute.sv
// Back end: holds the architectural registers and flags, executes one classified
// instruction per cycle unless a held result stalls it, and registers the result.
// Depends on c65x_pkg.
module c65x_execute import c65x_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  exec_item_t q_item,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_acc_out,
    output logic [7:0] m_x_out,
    output logic [7:0] m_y_out,
    output logic [7:0] m_sp_out,
    output logic [7:0] m_status_out,
    output logic [7:0] m_write_data,
    output logic       m_write_enable,
    output logic       m_branch_taken,
    output logic       m_unsupported
);
    logic [7:0] a_reg, x_reg, y_reg, s_reg;
    logic [5:0] f_reg;
    logic       ov_reg;
    logic [7:0] oa_reg, ox_reg, oy_reg, os_reg, ost_reg, owd_reg;
    logic       owe_reg, obr_reg, obad_reg;

    logic [7:0] a, x, y, s, m, wd, sh_in, sh_out, adc_in, cmp_reg, cmp_m, t, nz_v;
    logic       c, z, i, d, v, n, we, br, bad, sh_c, do_adc, do_cmp, do_nz, f;
    logic [1:0] sh_kind;
    logic [8:0] sum, diff;
    logic       go;

    assign m = q_item.operand;
    assign go = q_valid && q_ready;
    assign q_ready = !ov_reg || m_ready;

    always_comb begin
        case (sh_kind)
            2'd0: begin sh_out = {sh_in[6:0], 1'b0}; sh_c = sh_in[7]; end
            2'd1: begin sh_out = {sh_in[6:0], f_reg[0]}; sh_c = sh_in[7]; end
            2'd2: begin sh_out = {1'b0, sh_in[7:1]}; sh_c = sh_in[0]; end
            default: begin sh_out = {f_reg[0], sh_in[7:1]}; sh_c = sh_in[0]; end
        endcase
    end

    always_comb begin
        a = a_reg; x = x_reg; y = y_reg; s = s_reg;
        c = f_reg[0]; z = f_reg[1]; i = f_reg[2]; d = f_reg[3]; v = f_reg[4]; n = f_reg[5];
        wd = '0; we = 1'b0; br = 1'b0; bad = 1'b0;
        sh_kind = q_item.aaa[1:0]; sh_in = m;
        do_adc = 1'b0; adc_in = m; do_cmp = 1'b0; cmp_reg = a_reg; cmp_m = m;
        do_nz = 1'b0; nz_v = '0; t = a_reg & m; sum = '0; diff = '0; f = 1'b0;
        case (q_item.op)
            OP_BAD: bad = 1'b1;
            OP_ORA: begin a = a_reg | m; do_nz = 1'b1; nz_v = a; end
            OP_AND: begin a = a_reg & m; do_nz = 1'b1; nz_v = a; end
            OP_EOR: begin a = a_reg ^ m; do_nz = 1'b1; nz_v = a; end
            OP_ADC: do_adc = 1'b1;
            OP_SBC: begin do_adc = 1'b1; adc_in = ~m; end
            OP_STA: begin we = 1'b1; wd = a_reg; end
            OP_LDA: begin a = m; do_nz = 1'b1; nz_v = a; end
            OP_CMP: do_cmp = 1'b1;
            OP_LDX: begin x = m; do_nz = 1'b1; nz_v = x; end
            OP_ASLA, OP_ROLA, OP_LSRA, OP_RORA: begin
                sh_in = a_reg; a = sh_out; c = sh_c; do_nz = 1'b1; nz_v = a;
            end
            OP_TXA: begin a = x_reg; do_nz = 1'b1; nz_v = a; end
            OP_TAX: begin x = a_reg; do_nz = 1'b1; nz_v = x; end
            OP_DEX: begin x = x_reg - 8'h01; do_nz = 1'b1; nz_v = x; end
            OP_TXS: s = x_reg;
            OP_TSX: begin x = s_reg; do_nz = 1'b1; nz_v = x; end
            OP_ASLM, OP_ROLM, OP_LSRM, OP_RORM: begin
                wd = sh_out; we = 1'b1; c = sh_c; do_nz = 1'b1; nz_v = wd;
            end
            OP_STX: begin we = 1'b1; wd = x_reg; end
            OP_DEC: begin wd = m - 8'h01; we = 1'b1; do_nz = 1'b1; nz_v = wd; end
            OP_INC: begin wd = m + 8'h01; we = 1'b1; do_nz = 1'b1; nz_v = wd; end
            OP_ANC: begin a = t; do_nz = 1'b1; nz_v = a; c = t[7]; end
            OP_ALR: begin a = {1'b0, t[7:1]}; c = t[0]; do_nz = 1'b1; nz_v = a; end
            OP_ARR: begin
                a = {f_reg[0], t[7:1]}; do_nz = 1'b1; nz_v = a;
                c = a[6]; v = a[6] ^ a[5];
            end
            OP_AXS: begin
                diff = {1'b0, a_reg & x_reg} - {1'b0, m};
                c = !diff[8]; x = diff[7:0]; do_nz = 1'b1; nz_v = x;
            end
            OP_SLO: begin
                wd = sh_out; we = 1'b1; c = sh_c; a = a_reg | sh_out;
                do_nz = 1'b1; nz_v = a;
            end
            OP_RLA: begin
                wd = sh_out; we = 1'b1; c = sh_c; a = a_reg & sh_out;
                do_nz = 1'b1; nz_v = a;
            end
            OP_SRE: begin
                wd = sh_out; we = 1'b1; c = sh_c; a = a_reg ^ sh_out;
                do_nz = 1'b1; nz_v = a;
            end
            OP_RRA: begin
                wd = sh_out; we = 1'b1; c = sh_c; do_adc = 1'b1; adc_in = sh_out;
            end
            OP_SAX: begin we = 1'b1; wd = a_reg & x_reg; end
            OP_LAS: begin
                a = m & s_reg; x = a; s = a; do_nz = 1'b1; nz_v = a;
            end
            OP_LAX: begin a = m; x = m; do_nz = 1'b1; nz_v = m; end
            OP_DCP: begin wd = m - 8'h01; we = 1'b1; do_cmp = 1'b1; cmp_m = wd; end
            OP_ISC: begin
                wd = m + 8'h01; we = 1'b1; do_adc = 1'b1; adc_in = ~wd;
            end
            OP_BRANCH: begin
                case (q_item.aaa[2:1])
                    2'd0: f = n;
                    2'd1: f = v;
                    2'd2: f = c;
                    default: f = z;
                endcase
                br = f == q_item.aaa[0];
            end
            OP_PHP: begin wd = {n, v, 2'b11, d, i, z, c}; we = 1'b1; s = s_reg - 8'h01; end
            OP_PLP: begin
                s = s_reg + 8'h01;
                c = m[0]; z = m[1]; i = m[2]; d = m[3]; v = m[6]; n = m[7];
            end
            OP_PHA: begin wd = a_reg; we = 1'b1; s = s_reg - 8'h01; end
            OP_PLA: begin s = s_reg + 8'h01; a = m; do_nz = 1'b1; nz_v = a; end
            OP_DEY: begin y = y_reg - 8'h01; do_nz = 1'b1; nz_v = y; end
            OP_TAY: begin y = a_reg; do_nz = 1'b1; nz_v = y; end
            OP_INY: begin y = y_reg + 8'h01; do_nz = 1'b1; nz_v = y; end
            OP_INX: begin x = x_reg + 8'h01; do_nz = 1'b1; nz_v = x; end
            OP_CLC: c = 1'b0;
            OP_SEC: c = 1'b1;
            OP_CLI: i = 1'b0;
            OP_SEI: i = 1'b1;
            OP_TYA: begin a = y_reg; do_nz = 1'b1; nz_v = a; end
            OP_CLV: v = 1'b0;
            OP_CLD: d = 1'b0;
            OP_SED: d = 1'b1;
            OP_LDY: begin y = m; do_nz = 1'b1; nz_v = y; end
            OP_CPY: begin do_cmp = 1'b1; cmp_reg = y_reg; end
            OP_CPX: begin do_cmp = 1'b1; cmp_reg = x_reg; end
            OP_BIT: begin z = (a_reg & m) == 8'h00; v = m[6]; n = m[7]; end
            OP_STY: begin we = 1'b1; wd = y_reg; end
            default: ;
        endcase
        if (do_adc) begin
            sum = {1'b0, a_reg} + {1'b0, adc_in} + {8'h00, c};
            v = ((sum[7] ^ a_reg[7]) & (sum[7] ^ adc_in[7]));
            c = sum[8]; a = sum[7:0]; do_nz = 1'b1; nz_v = a;
        end
        if (do_cmp) begin
            diff = {1'b0, cmp_reg} - {1'b0, cmp_m};
            c = !diff[8]; do_nz = 1'b1; nz_v = diff[7:0];
        end
        if (do_nz) begin
            z = nz_v == 8'h00; n = nz_v[7];
        end
        if (bad) begin
            a = a_reg; x = x_reg; y = y_reg; s = s_reg;
            c = f_reg[0]; z = f_reg[1]; i = f_reg[2]; d = f_reg[3]; v = f_reg[4];
            n = f_reg[5]; we = 1'b0; wd = '0; br = 1'b0;
        end
    end

    assign m_valid = ov_reg;
    assign m_acc_out = oa_reg;
    assign m_x_out = ox_reg;
    assign m_y_out = oy_reg;
    assign m_sp_out = os_reg;
    assign m_status_out = ost_reg;
    assign m_write_data = owd_reg;
    assign m_write_enable = owe_reg;
    assign m_branch_taken = obr_reg;
    assign m_unsupported = obad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= '0; x_reg <= '0; y_reg <= '0; s_reg <= 8'hFD;
            f_reg <= 6'b000100; ov_reg <= 1'b0;
        end else begin
            if (go) begin
                a_reg <= a; x_reg <= x; y_reg <= y; s_reg <= s;
                f_reg <= {n, v, d, i, z, c};
            end
            if (q_ready) ov_reg <= q_valid;
        end
        if (go) begin
            oa_reg <= a; ox_reg <= x; oy_reg <= y; os_reg <= s;
            ost_reg <= {n, v, 2'b11, d, i, z, c};
            owd_reg <= wd; owe_reg <= we; obr_reg <= br; obad_reg <= bad;
        end
    end
endmodule

FILE: dv/cpu_6502_execute_unit_tb.sv
// Testbench for the 6502 execute unit: drives opcode/operand requests, predicts
// register, flag and write-back results per instruction and checks every result.
// Depends on the RTL of cpu_6502_execute_unit only.
module cpu_6502_execute_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] status;
        logic [7:0] wdata;
        logic       wen;
        logic       taken;
        logic       unsup;
    } cpu_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_opcode = '0;
    logic [7:0] s_operand = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_acc_out, m_x_out, m_y_out, m_sp_out, m_status_out, m_write_data;
    logic       m_write_enable, m_branch_taken, m_unsupported;

    cpu_6502_execute_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_operand(s_operand),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_acc_out(m_acc_out), .m_x_out(m_x_out), .m_y_out(m_y_out), .m_sp_out(m_sp_out),
        .m_status_out(m_status_out), .m_write_data(m_write_data),
        .m_write_enable(m_write_enable), .m_branch_taken(m_branch_taken),
        .m_unsupported(m_unsupported)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predicted architectural state.
    logic [7:0] reg_a, reg_x, reg_y, reg_sp;
    logic       fl_c, fl_z, fl_i, fl_d, fl_v, fl_n;
    cpu_result_t expected_results[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit sending_done = 1'b0;

    function automatic void set_nz(input logic [7:0] v);
        fl_z = (v == 8'h00);
        fl_n = v[7];
    endfunction

    function automatic void add_carry(input logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, reg_a} + {1'b0, m} + {8'h00, fl_c};
        fl_c = sum[8];
        fl_v = ((sum[7:0] ^ reg_a) & (sum[7:0] ^ m) & 8'h80) != 8'h00;
        reg_a = sum[7:0];
        set_nz(reg_a);
    endfunction

    function automatic void compare(input logic [7:0] r, input logic [7:0] m);
        fl_c = (r >= m);
        set_nz(r - m);
    endfunction

    function automatic logic [7:0] shift_byte(input logic [1:0] kind, input logic [7:0] v);
        logic [7:0] r;
        if (kind < 2'd2) begin
            r = {v[6:0], (kind == 2'd1) ? fl_c : 1'b0};
            fl_c = v[7];
        end else begin
            r = {(kind == 2'd3) ? fl_c : 1'b0, v[7:1]};
            fl_c = v[0];
        end
        set_nz(r);
        return r;
    endfunction

    function automatic logic [7:0] packed_status();
        return {fl_n, fl_v, 2'b11, fl_d, fl_i, fl_z, fl_c};
    endfunction

    function automatic void reset_state();
        reg_a = '0; reg_x = '0; reg_y = '0; reg_sp = 8'hFD;
        {fl_n, fl_v, fl_d, fl_i, fl_z, fl_c} = 6'b000100;
    endfunction

    function automatic cpu_result_t execute_instruction(input logic [7:0] op,
                                                        input logic [7:0] m);
        logic [1:0] cc;
        logic [2:0] aaa, bbb;
        logic       bad, wen, taken, f, low;
        logic [7:0] wd, t;
        logic [7:0] sa, sx, sy, ss;
        logic [5:0] sflags;
        cpu_result_t res;
        cc = op[1:0]; aaa = op[7:5]; bbb = op[4:2];
        bad = 1'b0; wen = 1'b0; taken = 1'b0; wd = '0; f = 1'b0; t = '0;
        sa = reg_a; sx = reg_x; sy = reg_y; ss = reg_sp;
        sflags = {fl_n, fl_v, fl_d, fl_i, fl_z, fl_c};
        if (cc == 2'd1) begin
            case (aaa)
                3'd0: begin reg_a |= m; set_nz(reg_a); end
                3'd1: begin reg_a &= m; set_nz(reg_a); end
                3'd2: begin reg_a ^= m; set_nz(reg_a); end
                3'd3: add_carry(m);
                3'd4: if (bbb != 3'd2) begin wen = 1'b1; wd = reg_a; end
                3'd5: begin reg_a = m; set_nz(reg_a); end
                3'd6: compare(reg_a, m);
                default: add_carry(~m);
            endcase
        end else if (cc == 2'd2) begin
            if (bbb == 3'd4) bad = 1'b1;
            else if (bbb == 3'd0) begin
                if (aaa == 3'd5) begin reg_x = m; set_nz(reg_x); end
                else if (aaa < 3'd4) bad = 1'b1;
            end else if (bbb == 3'd2) begin
                if (aaa < 3'd4) reg_a = shift_byte(aaa[1:0], reg_a);
                else if (aaa == 3'd4) begin reg_a = reg_x; set_nz(reg_a); end
                else if (aaa == 3'd5) begin reg_x = reg_a; set_nz(reg_x); end
                else if (aaa == 3'd6) begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
            end else if (bbb == 3'd6) begin
                if (aaa == 3'd4) reg_sp = reg_x;
                else if (aaa == 3'd5) begin reg_x = reg_sp; set_nz(reg_x); end
            end else begin
                if (aaa < 3'd4) begin wd = shift_byte(aaa[1:0], m); wen = 1'b1; end
                else if (aaa == 3'd4) begin
                    if (op == 8'h9E) bad = 1'b1;
                    else begin wen = 1'b1; wd = reg_x; end
                end else if (aaa == 3'd5) begin reg_x = m; set_nz(reg_x); end
                else if (aaa == 3'd6) begin wd = m - 8'd1; wen = 1'b1; set_nz(wd); end
                else begin wd = m + 8'd1; wen = 1'b1; set_nz(wd); end
            end
        end else if (cc == 2'd3) begin
            if (bbb == 3'd2) begin
                case (aaa)
                    3'd0, 3'd1: begin reg_a &= m; set_nz(reg_a); fl_c = fl_n; end
                    3'd2: begin
                        t = reg_a & m; fl_c = t[0]; reg_a = t >> 1; set_nz(reg_a);
                    end
                    3'd3: begin
                        t = reg_a & m;
                        reg_a = {fl_c, t[7:1]};
                        set_nz(reg_a);
                        fl_c = reg_a[6];
                        fl_v = reg_a[6] ^ reg_a[5];
                    end
                    3'd4, 3'd5: bad = 1'b1;
                    3'd6: begin
                        t = reg_a & reg_x; fl_c = (t >= m); reg_x = t - m; set_nz(reg_x);
                    end
                    default: add_carry(~m);
                endcase
            end else begin
                case (aaa)
                    3'd0: begin
                        wd = shift_byte(2'd0, m); wen = 1'b1; reg_a |= wd; set_nz(reg_a);
                    end
                    3'd1: begin
                        wd = shift_byte(2'd1, m); wen = 1'b1; reg_a &= wd; set_nz(reg_a);
                    end
                    3'd2: begin
                        wd = shift_byte(2'd2, m); wen = 1'b1; reg_a ^= wd; set_nz(reg_a);
                    end
                    3'd3: begin wd = shift_byte(2'd3, m); wen = 1'b1; add_carry(wd); end
                    3'd4: if (op == 8'h93 || op == 8'h9F || op == 8'h9B) bad = 1'b1;
                       else begin wen = 1'b1; wd = reg_a & reg_x; end
                    3'd5: if (op == 8'hBB) begin
                           t = m & reg_sp; reg_a = t; reg_x = t; reg_sp = t; set_nz(t);
                       end else begin
                           reg_a = m; reg_x = m; set_nz(m);
                       end
                    3'd6: begin wd = m - 8'd1; wen = 1'b1; compare(reg_a, wd); end
                    default: begin wd = m + 8'd1; wen = 1'b1; add_carry(~wd); end
                endcase
            end
        end else begin
            if (bbb == 3'd4) begin
                case (aaa[2:1])
                    2'd0: f = fl_n;
                    2'd1: f = fl_v;
                    2'd2: f = fl_c;
                    default: f = fl_z;
                endcase
                taken = (f == aaa[0]);
            end else if (bbb == 3'd2) begin
                case (aaa)
                    3'd0: begin wd = packed_status(); wen = 1'b1; reg_sp = reg_sp - 8'd1; end
                    3'd1: begin
                        reg_sp = reg_sp + 8'd1;
                        {fl_n, fl_v, fl_d, fl_i, fl_z, fl_c} = {m[7:6], m[3:0]};
                    end
                    3'd2: begin wd = reg_a; wen = 1'b1; reg_sp = reg_sp - 8'd1; end
                    3'd3: begin reg_sp = reg_sp + 8'd1; reg_a = m; set_nz(reg_a); end
                    3'd4: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
                    3'd5: begin reg_y = reg_a; set_nz(reg_y); end
                    3'd6: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
                    default: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
                endcase
            end else if (bbb == 3'd6) begin
                case (aaa)
                    3'd0: fl_c = 1'b0;
                    3'd1: fl_c = 1'b1;
                    3'd2: fl_i = 1'b0;
                    3'd3: fl_i = 1'b1;
                    3'd4: begin reg_a = reg_y; set_nz(reg_a); end
                    3'd5: fl_v = 1'b0;
                    3'd6: fl_d = 1'b0;
                    default: fl_d = 1'b1;
                endcase
            end else if (bbb == 3'd0) begin
                if (aaa < 3'd4) bad = 1'b1;
                else if (aaa == 3'd5) begin reg_y = m; set_nz(reg_y); end
                else if (aaa == 3'd6) compare(reg_y, m);
                else if (aaa == 3'd7) compare(reg_x, m);
            end else begin
                low = (bbb == 3'd1 || bbb == 3'd3);
                case (aaa)
                    3'd1: if (low) begin
                           fl_z = ((reg_a & m) == 8'h00); fl_v = m[6]; fl_n = m[7];
                       end
                    3'd2, 3'd3: if (bbb == 3'd3) bad = 1'b1;
                    3'd4: if (op == 8'h9C) bad = 1'b1;
                       else if (bbb != 3'd7) begin wen = 1'b1; wd = reg_y; end
                    3'd5: begin reg_y = m; set_nz(reg_y); end
                    3'd6: if (low) compare(reg_y, m);
                    3'd7: if (low) compare(reg_x, m);
                    default: ;
                endcase
            end
        end
        if (bad) begin
            reg_a = sa; reg_x = sx; reg_y = sy; reg_sp = ss;
            {fl_n, fl_v, fl_d, fl_i, fl_z, fl_c} = sflags;
            wen = 1'b0; taken = 1'b0;
        end
        if (!wen) wd = '0;
        res.acc = reg_a; res.x = reg_x; res.y = reg_y; res.sp = reg_sp;
        res.status = packed_status(); res.wdata = wd; res.wen = wen;
        res.taken = taken; res.unsup = bad;
        return res;
    endfunction

    task automatic send_instruction(input logic [7:0] op, input logic [7:0] m,
                                    input bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap) begin
            gap = ($urandom_range(0, 99) < 4) ? $urandom_range(10, 40)
                  : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_operand <= m;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(execute_instruction(op, m));
    endtask

    task automatic test_directed();
        logic [7:0] ops[$];
        ops = '{8'hA9, 8'hA2, 8'hA0, 8'h69, 8'h69, 8'hE9, 8'h38, 8'h08, 8'h28, 8'h48,
                8'h68, 8'h9A, 8'hBA, 8'h02, 8'h00, 8'h8B, 8'h9C, 8'h24, 8'h30, 8'hD0,
                8'h0B, 8'h6B, 8'hCB, 8'hBB, 8'h1A};
        foreach (ops[i]) begin
            send_instruction(ops[i], (i % 2 == 0) ? 8'hFF : ((i % 3 == 0) ? 8'h00 : 8'h7F),
                             1'b0);
        end
        send_instruction(8'h69, 8'h80, 1'b0);
        send_instruction(8'h69, 8'h01, 1'b0);
    endtask

    task automatic test_opcode_sweep();
        for (int op = 0; op < 256; op++) begin
            send_instruction(op[7:0], 8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_instruction(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_instruction(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(posedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
            if (idle_cycles >= 60) begin
                hold_off <= 1'b0;
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end else if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) < 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        cpu_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_acc_out, m_x_out, m_y_out, m_sp_out, m_status_out, m_write_data,
                   m_write_enable, m_branch_taken, m_unsupported};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected a=%h x=%h y=%h sp=%h p=%h wd=%h we=%b br=%b u=%b",
                                 want.acc, want.x, want.y, want.sp, want.status, want.wdata,
                                 want.wen, want.taken, want.unsup);
                        $display("          actual   a=%h x=%h y=%h sp=%h p=%h wd=%h we=%b br=%b u=%b",
                                 got.acc, got.x, got.y, got.sp, got.status, got.wdata,
                                 got.wen, got.taken, got.unsup);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    int stuck_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_off) begin
            stuck_cycles <= 0;
        end else if (!sending_done || expected_results.size() != 0) begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        reset_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_opcode_sweep();
        test_backpressure();
        test_random(1450);
        s_valid <= 1'b0;
        sending_done = 1'b1;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
